FILE: src/qtu_pkg.sv
package qtu_pkg;

    localparam int unsigned COUNT_W = 16;
    localparam logic [COUNT_W-1:0] MAX_LEN = 16'd65535;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned LEVEL_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_LC_B = 8'h62;
    localparam logic [7:0] CH_LC_F = 8'h66;
    localparam logic [7:0] CH_LC_N = 8'h6e;
    localparam logic [7:0] CH_LC_R = 8'h72;
    localparam logic [7:0] CH_LC_T = 8'h74;
    localparam logic [7:0] CH_LC_X = 8'h78;
    localparam logic [7:0] CH_LC_A = 8'h61;
    localparam logic [7:0] CH_LC_Z = 8'h7a;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] HEX_ALPHA_OFS = 8'h41 - 8'd10;
    localparam logic [7:0] CASE_DIFF = 8'h20;

    localparam logic [7:0] CC_BS = 8'h08;
    localparam logic [7:0] CC_FF = 8'h0c;
    localparam logic [7:0] CC_LF = 8'h0a;
    localparam logic [7:0] CC_CR = 8'h0d;
    localparam logic [7:0] CC_TAB = 8'h09;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_END    = 2'd1,
        KIND_BADESC = 2'd2,
        KIND_TRUNC  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         data;
        logic [COUNT_W-1:0] count;
        logic               eot;
    } result_t;

    // Up to two results per input item: a decoded byte or error, then the close.
    typedef struct packed {
        logic    first_vld;
        logic    close_vld;
        result_t first;
        result_t close;
    } push_t;

    // Unchecked hex digit value, kept to 8 bits.
    function automatic logic [7:0] hex_value(input logic [7:0] b);
        logic [7:0] u;
        u = b;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            return b - CH_ZERO;
        end
        if (b >= CH_LC_A && b <= CH_LC_Z) begin
            u = b - CASE_DIFF;
        end
        return u - HEX_ALPHA_OFS;
    endfunction

endpackage

FILE: src/qtu_decode.sv
module qtu_decode (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_accept,
    input  logic [7:0]      in_byte,
    input  logic            is_last,
    output qtu_pkg::push_t  push
);

    typedef enum logic [1:0] {
        POS_FIRST  = 2'd0,
        POS_SECOND = 2'd1,
        POS_REST   = 2'd2
    } pos_t;

    typedef enum logic [1:0] {
        HEX_IDLE = 2'd0,
        HEX_HIGH = 2'd1,
        HEX_LOW  = 2'd2
    } hex_t;

    pos_t                        pos_reg, pos_next;
    logic                        quoted_reg, quoted_next;
    logic                        esc_reg, esc_next;
    hex_t                        hex_reg, hex_next;
    logic [7:0]                  high_reg, high_next;
    logic [qtu_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                        drop_reg, drop_next;

    logic                        payload;
    logic                        emit_byte;
    logic [7:0]                  byte_val;
    logic                        emit_err;
    logic [qtu_pkg::COUNT_W-1:0] count_step;

    always_comb begin
        pos_next    = pos_reg;
        quoted_next = quoted_reg;
        esc_next    = esc_reg;
        hex_next    = hex_reg;
        high_next   = high_reg;
        drop_next   = drop_reg;
        payload     = 1'b0;
        emit_byte   = 1'b0;
        emit_err    = 1'b0;
        byte_val    = in_byte;

        case (pos_reg)
            POS_FIRST: begin
                if (in_byte == qtu_pkg::CH_QUOTE) begin
                    quoted_next = 1'b1;
                end
                pos_next = POS_SECOND;
            end
            POS_SECOND: begin
                if (!quoted_reg && in_byte == qtu_pkg::CH_QUOTE) begin
                    quoted_next = 1'b1;
                end else begin
                    payload = !(quoted_reg && is_last);
                end
                pos_next = POS_REST;
            end
            default: begin
                payload = !(quoted_reg && is_last);
            end
        endcase

        if (payload && !drop_reg) begin
            if (hex_reg == HEX_HIGH) begin
                high_next = qtu_pkg::hex_value(in_byte);
                hex_next  = HEX_LOW;
            end else if (hex_reg != HEX_IDLE) begin
                emit_byte = 1'b1;
                byte_val  = {high_reg[3:0], 4'd0} + qtu_pkg::hex_value(in_byte);
                hex_next  = HEX_IDLE;
            end else if (esc_reg) begin
                esc_next = 1'b0;
                case (in_byte)
                    qtu_pkg::CH_QUOTE, qtu_pkg::CH_BSLASH, qtu_pkg::CH_SLASH: begin
                        emit_byte = 1'b1;
                    end
                    qtu_pkg::CH_LC_B: begin
                        emit_byte = 1'b1;
                        byte_val  = qtu_pkg::CC_BS;
                    end
                    qtu_pkg::CH_LC_F: begin
                        emit_byte = 1'b1;
                        byte_val  = qtu_pkg::CC_FF;
                    end
                    qtu_pkg::CH_LC_N: begin
                        emit_byte = 1'b1;
                        byte_val  = qtu_pkg::CC_LF;
                    end
                    qtu_pkg::CH_LC_R: begin
                        emit_byte = 1'b1;
                        byte_val  = qtu_pkg::CC_CR;
                    end
                    qtu_pkg::CH_LC_T: begin
                        emit_byte = 1'b1;
                        byte_val  = qtu_pkg::CC_TAB;
                    end
                    qtu_pkg::CH_LC_X: begin
                        hex_next = HEX_HIGH;
                    end
                    default: begin
                        drop_next = 1'b1;
                        emit_err  = 1'b1;
                    end
                endcase
            end else if (in_byte == qtu_pkg::CH_BSLASH) begin
                esc_next = 1'b1;
            end else begin
                emit_byte = 1'b1;
            end
        end

        count_step = count_reg;
        if (emit_byte && count_reg < qtu_pkg::MAX_LEN) begin
            count_step = count_reg + 1'b1;
        end
        count_next = count_step;

        push.first_vld   = in_accept && (emit_byte || emit_err);
        push.first.kind  = emit_byte ? qtu_pkg::KIND_BYTE : qtu_pkg::KIND_BADESC;
        push.first.data  = emit_byte ? byte_val : 8'd0;
        push.first.count = count_step;
        push.first.eot   = 1'b0;

        push.close_vld   = in_accept && is_last;
        push.close.kind  = drop_next ? qtu_pkg::KIND_BADESC :
                           (hex_next != HEX_IDLE ? qtu_pkg::KIND_TRUNC : qtu_pkg::KIND_END);
        push.close.data  = 8'd0;
        push.close.count = count_step;
        push.close.eot   = 1'b1;

        // Final byte returns the token state to its cleared form.
        if (is_last) begin
            pos_next    = POS_FIRST;
            quoted_next = 1'b0;
            esc_next    = 1'b0;
            hex_next    = HEX_IDLE;
            high_next   = 8'd0;
            count_next  = '0;
            drop_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= POS_FIRST;
            quoted_reg <= 1'b0;
            esc_reg    <= 1'b0;
            hex_reg    <= HEX_IDLE;
            high_reg   <= 8'd0;
            count_reg  <= '0;
            drop_reg   <= 1'b0;
        end else if (in_accept) begin
            pos_reg    <= pos_next;
            quoted_reg <= quoted_next;
            esc_reg    <= esc_next;
            hex_reg    <= hex_next;
            high_reg   <= high_next;
            count_reg  <= count_next;
            drop_reg   <= drop_next;
        end
    end

    a_esc_hex_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(esc_reg && hex_reg != HEX_IDLE))
        else $error("escape and hex decode active together");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && is_last |=> pos_reg == POS_FIRST && count_reg == '0 && !drop_reg)
        else $error("token state not cleared after final byte");

    a_drop_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        drop_reg && in_accept |-> !push.first_vld)
        else $error("result emitted while dropping after bad escape");

endmodule

FILE: src/qtu_result_fifo.sv
module qtu_result_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  qtu_pkg::push_t    push,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output qtu_pkg::result_t  out_item
);

    qtu_pkg::result_t                 mem_reg [qtu_pkg::FIFO_DEPTH];
    logic [qtu_pkg::PTR_W-1:0]        wr_reg, wr_next;
    logic [qtu_pkg::PTR_W-1:0]        rd_reg, rd_next;
    logic [qtu_pkg::LEVEL_W-1:0]      level_reg, level_next;
    logic [qtu_pkg::PTR_W-1:0]        close_addr;
    logic                             pop;
    logic [qtu_pkg::LEVEL_W-1:0]      n_push;

    assign room      = level_reg <= qtu_pkg::LEVEL_W'(qtu_pkg::FIFO_DEPTH - 2);
    assign out_valid = level_reg != '0;
    assign out_item  = mem_reg[rd_reg];
    assign pop       = out_valid && out_ready;

    always_comb begin
        n_push     = qtu_pkg::LEVEL_W'(push.first_vld) + qtu_pkg::LEVEL_W'(push.close_vld);
        close_addr = wr_reg + qtu_pkg::PTR_W'(push.first_vld);
        wr_next    = wr_reg + qtu_pkg::PTR_W'(n_push);
        rd_next    = rd_reg + qtu_pkg::PTR_W'(pop);
        level_next = level_reg + n_push - qtu_pkg::LEVEL_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.first_vld) begin
            mem_reg[wr_reg] <= push.first;
        end
        if (push.close_vld) begin
            mem_reg[close_addr] <= push.close;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            level_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            level_reg <= level_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= qtu_pkg::LEVEL_W'(qtu_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    a_push_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.first_vld || push.close_vld) |-> room)
        else $error("push without room");

    a_ptr_level: assert property (@(posedge aclk) disable iff (!aresetn)
        qtu_pkg::PTR_W'(wr_reg - rd_reg) == qtu_pkg::PTR_W'(level_reg))
        else $error("queue pointers disagree with level");

endmodule

FILE: src/quoted_token_unescaper_unit.sv
// Results are registered in the result queue when their input item is accepted.
// Throughput: one input item per cycle while s_tready is high; a token's final byte can
// yield two results, which leave one per cycle while m_tready is high, through a four-entry result queue.
// s_tready is high while the queue has room for two results.
// Reset: aresetn, synchronous, active low; clears token state and empties the queue.
module quoted_token_unescaper_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] payload_count
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast    // end_of_token
);

    qtu_pkg::push_t   push;
    qtu_pkg::result_t head;
    logic             room;
    logic             in_accept;

    assign s_tready  = room;
    assign in_accept = s_tvalid && room;

    qtu_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .is_last   (s_tlast),
        .push      (push)
    );

    qtu_result_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (head)
    );

    assign m_tdata = {head.count, head.data};
    assign m_tuser = head.kind;
    assign m_tlast = head.eot;

endmodule

FILE: verif/qtu_result_checker.sv
module qtu_result_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // is_last
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] payload_count
    input  logic [1:0]  m_tuser,   // [1:0] kind
    input  logic        m_tlast,   // end_of_token
    output int          fail_count,
    output int          outstanding
);

    // Token decoder state, mirrored from the bytes seen on the input channel
    logic [1:0]                  tok_pos;
    logic                        in_quotes;
    logic                        esc_seen;
    logic [1:0]                  hex_step;
    logic [7:0]                  hi_digit;
    logic [qtu_pkg::COUNT_W-1:0] n_decoded;
    logic                        skip_rest;

    qtu_pkg::result_t pending_results[$];

    task automatic restart_token();
        tok_pos = 2'd0;
        in_quotes = 1'b0;
        esc_seen = 1'b0;
        hex_step = 2'd0;
        hi_digit = 8'h00;
        n_decoded = '0;
        skip_rest = 1'b0;
    endtask

    // Digit value without range check; letters are folded to upper case first.
    function automatic logic [7:0] digit_of(input logic [7:0] c);
        logic [7:0] up;
        if (c >= qtu_pkg::CH_ZERO && c <= qtu_pkg::CH_NINE) begin
            return {4'h0, c[3:0]};
        end
        up = (c >= qtu_pkg::CH_LC_A && c <= qtu_pkg::CH_LC_Z) ? (c & ~qtu_pkg::CASE_DIFF) : c;
        return up - qtu_pkg::HEX_ALPHA_OFS;
    endfunction

    task automatic add_result(input qtu_pkg::kind_t k, input logic [7:0] d, input logic eot);
        qtu_pkg::result_t r;
        r.kind = k;
        r.data = d;
        r.count = n_decoded;
        r.eot = eot;
        pending_results.push_back(r);
    endtask

    task automatic add_decoded(input logic [7:0] d);
        if (n_decoded < qtu_pkg::MAX_LEN) begin
            n_decoded = n_decoded + 1'b1;
        end
        add_result(qtu_pkg::KIND_BYTE, d, 1'b0);
    endtask

    task automatic decode_byte(input logic [7:0] c, input logic fin);
        logic           take;
        qtu_pkg::kind_t close_kind;
        take = 1'b0;
        case (tok_pos)
            2'd0: begin
                if (c == qtu_pkg::CH_QUOTE) begin
                    in_quotes = 1'b1;
                end
                tok_pos = 2'd1;
            end
            2'd1: begin
                // a quote in second place also opens a quoted token
                if (!in_quotes && c == qtu_pkg::CH_QUOTE) begin
                    in_quotes = 1'b1;
                end else if (!(in_quotes && fin)) begin
                    take = 1'b1;
                end
                tok_pos = 2'd2;
            end
            default: begin
                take = !(in_quotes && fin);
            end
        endcase

        if (take && !skip_rest) begin
            if (hex_step == 2'd1) begin
                hi_digit = digit_of(c);
                hex_step = 2'd2;
            end else if (hex_step != 2'd0) begin
                add_decoded({hi_digit[3:0], 4'h0} + digit_of(c));
                hex_step = 2'd0;
            end else if (esc_seen) begin
                esc_seen = 1'b0;
                case (c)
                    qtu_pkg::CH_QUOTE, qtu_pkg::CH_BSLASH, qtu_pkg::CH_SLASH: add_decoded(c);
                    qtu_pkg::CH_LC_B: add_decoded(qtu_pkg::CC_BS);
                    qtu_pkg::CH_LC_F: add_decoded(qtu_pkg::CC_FF);
                    qtu_pkg::CH_LC_N: add_decoded(qtu_pkg::CC_LF);
                    qtu_pkg::CH_LC_R: add_decoded(qtu_pkg::CC_CR);
                    qtu_pkg::CH_LC_T: add_decoded(qtu_pkg::CC_TAB);
                    qtu_pkg::CH_LC_X: hex_step = 2'd1;
                    default: begin
                        skip_rest = 1'b1;
                        add_result(qtu_pkg::KIND_BADESC, 8'h00, 1'b0);
                    end
                endcase
            end else if (c == qtu_pkg::CH_BSLASH) begin
                esc_seen = 1'b1;
            end else begin
                add_decoded(c);
            end
        end

        if (fin) begin
            if (skip_rest) begin
                close_kind = qtu_pkg::KIND_BADESC;
            end else if (hex_step != 2'd0) begin
                close_kind = qtu_pkg::KIND_TRUNC;
            end else begin
                close_kind = qtu_pkg::KIND_END;
            end
            add_result(close_kind, 8'h00, 1'b1);
            restart_token();
        end
    endtask

    always @(posedge aclk) begin
        qtu_pkg::result_t want;
        if (!aresetn) begin
            restart_token();
            pending_results.delete();
        end else begin
            // results are registered in the queue when their item is accepted, so compare before predicting
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result: kind %0d out_byte %02h count %0d eot %0d",
                           m_tuser, m_tdata[7:0], m_tdata[23:8], m_tlast);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_tuser !== want.kind) begin
                        $error("kind: expected %0d, actual %0d", want.kind, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[7:0] !== want.data) begin
                        $error("out_byte: expected %02h, actual %02h", want.data, m_tdata[7:0]);
                        fail_count++;
                    end
                    if (m_tdata[23:8] !== want.count) begin
                        $error("payload_count: expected %0d, actual %0d",
                               want.count, m_tdata[23:8]);
                        fail_count++;
                    end
                    if (m_tlast !== want.eot) begin
                        $error("end_of_token: expected %0d, actual %0d", want.eot, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata, s_tlast);
            end
        end
        outstanding = pending_results.size();
    end

endmodule

FILE: verif/tb_quoted_token_unescaper_unit.sv
module tb_quoted_token_unescaper_unit;

    localparam int RANDOM_ITEMS = 1500;
    localparam int HOLD_CYCLES = 60;
    localparam int QUIET_LIMIT = 2000;
    localparam string HEX_DIGITS = "0123456789abcdefABCDEF";

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] in_byte
    logic        s_tlast = 1'b0;    // is_last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;           // [7:0] out_byte, [23:8] payload_count
    logic [1:0]  m_tuser;           // [1:0] kind
    logic        m_tlast;           // end_of_token

    int          fail_count;
    int          outstanding;

    logic        s_fire = 1'b0;
    int          quiet_cycles = 0;
    int          burst_left = 0;
    int          n_items = 0;
    logic [7:0]  tok[$];

    bit          hold_req = 1'b0;
    bit          hold_taken = 1'b0;
    int          hold_left = 0;
    logic [15:0] rx_pat = 16'hffff;
    int          rx_bit = 0;

    logic [7:0]  known_escapes[8] = '{qtu_pkg::CH_QUOTE, qtu_pkg::CH_BSLASH,
                                      qtu_pkg::CH_SLASH, qtu_pkg::CH_LC_B,
                                      qtu_pkg::CH_LC_F, qtu_pkg::CH_LC_N,
                                      qtu_pkg::CH_LC_R, qtu_pkg::CH_LC_T};

    quoted_token_unescaper_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    qtu_result_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // input handshake seen at the edge, read by the driver at the next falling edge
    always @(posedge aclk) begin
        s_fire <= s_tvalid && s_tready;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver: rotating 16-bit stall pattern, plus one long hold on request
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= rx_pat[rx_bit];
            if (rx_bit == 15) begin
                rx_bit = 0;
                rx_pat = ($urandom_range(0, 3) == 0) ? 16'hffff
                                                     : (16'($urandom) | 16'($urandom));
            end else begin
                rx_bit = rx_bit + 1;
            end
        end
    end

    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(32, 126));
        end while (c == qtu_pkg::CH_QUOTE || c == qtu_pkg::CH_BSLASH);
        return c;
    endfunction

    function automatic logic [7:0] hex_char();
        if ($urandom_range(0, 9) == 0) begin
            return 8'($urandom);
        end
        return HEX_DIGITS[$urandom_range(0, 21)];
    endfunction

    task automatic push_byte(input logic [7:0] c, input logic fin);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                s_tdata <= 8'($urandom);
                s_tlast <= 1'($urandom);
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tlast <= fin;
        do @(negedge aclk); while (!s_fire);
    endtask

    task automatic send_tok();
        for (int i = 0; i < tok.size(); i++) begin
            push_byte(tok[i], i == tok.size() - 1);
            n_items++;
        end
        tok.delete();
    endtask

    task automatic load(input string s);
        for (int i = 0; i < s.len(); i++) begin
            tok.push_back(s[i]);
        end
    endtask

    // Mostly well-formed tokens with random content; some noise and cut-off tokens.
    task automatic make_token();
        int         sel;
        int         pieces;
        logic       quoted;
        logic [7:0] c;
        tok.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) begin
                case ($urandom_range(0, 4))
                    0: c = qtu_pkg::CH_QUOTE;
                    1: c = qtu_pkg::CH_BSLASH;
                    2: c = qtu_pkg::CH_LC_X;
                    default: c = 8'($urandom);
                endcase
                tok.push_back(c);
            end
        end else begin
            sel = $urandom_range(0, 9);
            quoted = (sel < 8);
            if (sel < 6) begin
                tok.push_back(qtu_pkg::CH_QUOTE);
            end else begin
                tok.push_back(plain_byte());
                if (sel < 8) begin
                    tok.push_back(qtu_pkg::CH_QUOTE);
                end
            end
            pieces = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 8);
            repeat (pieces) begin
                sel = $urandom_range(0, 19);
                if (sel < 9) begin
                    tok.push_back(plain_byte());
                end else if (sel < 11) begin
                    tok.push_back(8'($urandom));
                end else if (sel < 15) begin
                    tok.push_back(qtu_pkg::CH_BSLASH);
                    tok.push_back(known_escapes[$urandom_range(0, 7)]);
                end else if (sel < 19) begin
                    tok.push_back(qtu_pkg::CH_BSLASH);
                    tok.push_back(qtu_pkg::CH_LC_X);
                    tok.push_back(hex_char());
                    tok.push_back(hex_char());
                end else begin
                    tok.push_back(qtu_pkg::CH_BSLASH);
                    tok.push_back(8'($urandom));
                end
            end
            if (quoted) begin
                tok.push_back(qtu_pkg::CH_QUOTE);
            end
            // cut the tail off now and then: ends inside escapes and hex pairs
            if ($urandom_range(0, 19) == 0 && tok.size() > 1) begin
                repeat ($urandom_range(1, tok.size() - 1)) tok.delete(tok.size() - 1);
            end
        end
    endtask

    initial begin
        bit hold_done;
        bit pause_done;
        hold_done = 1'b0;
        pause_done = 1'b0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // one-byte quote, quote in second place, truncated hex at closing quote
        load("\"");
        send_tok();
        load("a\"");
        send_tok();
        load("\"\\x4\"");
        send_tok();
        // mixed-case hex, then NUL and 0xff as plain payload on an unquoted token
        load("q\\xFf");
        tok.push_back(8'h00);
        tok.push_back(8'hff);
        send_tok();
        // unrecognized escape on the final byte, lone trailing backslash, tab
        load("z\\q");
        send_tok();
        load("\"\\\"");
        send_tok();
        load("x\\t");
        send_tok();

        n_items = 0;
        while (n_items < RANDOM_ITEMS) begin
            if (!hold_done && n_items >= RANDOM_ITEMS / 4) begin
                hold_req = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && n_items >= RANDOM_ITEMS * 3 / 5) begin
                s_tvalid <= 1'b0;
                do @(negedge aclk); while (outstanding != 0);
                pause_done = 1'b1;
            end
            make_token();
            send_tok();
        end

        s_tvalid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        repeat (8) @(negedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
